>>> rtl/core/sis_pkg.sv
package sis_pkg;

	localparam int COEF_W     = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int NUM_TERMS  = 3;
	localparam int WL_W       = 16;
	localparam int MAG_W      = 16;
	localparam int L2_NUM_W   = 56;
	localparam int L2_DIV_W   = 20;
	localparam int L2_W       = 35;
	localparam int L2_SQ_W    = 2 * MAG_W;
	localparam int L2_P_W     = 64;
	localparam int L2_SH      = 45;
	localparam int L2_A_W     = 17;
	localparam int L2_R_W     = 14;
	localparam int L2_FR_W    = 18;
	localparam int DIFF_W     = COEF_W + 1;
	localparam int MUL_H      = 24;
	localparam int PROD_W     = 2 * COEF_W;
	localparam int UNUM_W     = PROD_W + 24;
	localparam int TQ_W       = 61;
	localparam int RAD_W      = 64;
	localparam int USUM_W     = 62;
	localparam int PM_W       = 47;
	localparam int PMU_W      = 78;
	localparam int NQ_W       = 32;
	localparam int DQ_W       = 52;
	localparam int SL_NUM_W   = 120;
	localparam int SL_Q_W     = 33;
	localparam int SLOPE_W    = 32;
	localparam int STATUS_W   = 2;

	localparam logic [COEF_W-1:0] B1_RESET = 48'd5530786883;
	localparam logic [COEF_W-1:0] B2_RESET = 48'd2225844694;
	localparam logic [COEF_W-1:0] B3_RESET = 48'd112423392768;
	localparam logic [COEF_W-1:0] C1_RESET = 48'd23946243;
	localparam logic [COEF_W-1:0] C2_RESET = 48'd96069624;
	localparam logic [COEF_W-1:0] C3_RESET = 48'd8127166039248;

	// ceil(2^45 / 15625); exact floor division for numerators below 2^32.
	localparam logic [L2_SQ_W-1:0]  L2_RCP    = 32'd2251799814;
	localparam logic [L2_SQ_W-1:0]  L2_ODD    = 32'd15625;
	localparam logic [L2_SQ_W-1:0]  L2_BIAS   = 32'd7812;
	localparam logic [L2_DIV_W-1:0] L2_DIV    = 20'd1000000;
	localparam logic [TQ_W-1:0]     LIM60     = 61'h1000_0000_0000_0000;
	localparam logic [RAD_W-1:0]    RAD_ONE   = 64'h0000_0001_0000_0000;
	localparam logic [NQ_W-1:0]     AVG_INDEX = 32'd1814623683;
	localparam logic [SL_Q_W-1:0]   LIM_POS   = 33'h0_7FFF_FFFF;
	localparam logic [SL_Q_W-1:0]   LIM_NEG   = 33'h0_8000_0000;

	localparam logic [STATUS_W-1:0] ST_NORMAL  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_AVERAGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_B1 = 3'd0,
		REG_B2 = 3'd1,
		REG_B3 = 3'd2,
		REG_C1 = 3'd3,
		REG_C2 = 3'd4,
		REG_C3 = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [2*MUL_H-1:0] p00;
		logic [2*MUL_H-1:0] p01;
		logic [2*MUL_H-1:0] p10;
		logic [2*MUL_H-1:0] p11;
	} pp_t;

	function automatic pp_t mul_split(input logic [COEF_W-1:0] a, input logic [COEF_W-1:0] b);
		pp_t p;
		p.p00 = a[MUL_H-1:0] * b[MUL_H-1:0];
		p.p01 = a[MUL_H-1:0] * b[COEF_W-1:MUL_H];
		p.p10 = a[COEF_W-1:MUL_H] * b[MUL_H-1:0];
		p.p11 = a[COEF_W-1:MUL_H] * b[COEF_W-1:MUL_H];
		return p;
	endfunction

	function automatic logic [PROD_W-1:0] mul_join(input pp_t p);
		logic [PROD_W-1:0] s;
		s = PROD_W'(p.p00) + (PROD_W'(p.p01) << MUL_H) + (PROD_W'(p.p10) << MUL_H)
			+ {p.p11, {(2*MUL_H){1'b0}}};
		return s;
	endfunction

endpackage

>>> rtl/core/sis_udiv.sv
module sis_udiv import sis_pkg::*; #(
	parameter int N_W = L2_NUM_W,
	parameter int D_W = L2_DIV_W,
	parameter int Q_W = L2_W,
	parameter int S_W = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_v,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	input  logic [S_W-1:0] side_in,
	output logic           out_v,
	output logic [Q_W-1:0] quo,
	output logic           ovf,
	output logic [S_W-1:0] side_out
);

	localparam int H_W = N_W - Q_W;
	localparam int C_W = (H_W > D_W) ? H_W : D_W;

	logic           v_s    [Q_W+1];
	logic [Q_W-1:0] quo_s  [Q_W+1];
	logic           ovf_s  [Q_W+1];
	logic [S_W-1:0] side_s [Q_W+1];
	logic [D_W-1:0] rem_s  [Q_W];
	logic [Q_W-1:0] low_s  [Q_W];
	logic [D_W-1:0] den_s  [Q_W];

	logic [C_W-1:0] hi_ext;
	logic [C_W-1:0] den_ext;

	// The upper numerator bits form the first remainder; if they already reach
	// the divisor, the quotient does not fit in Q_W bits.
	assign hi_ext  = C_W'(num[N_W-1:Q_W]);
	assign den_ext = C_W'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= hi_ext[D_W-1:0];
			low_s[0]  <= num[Q_W-1:0];
			den_s[0]  <= den;
			quo_s[0]  <= '0;
			ovf_s[0]  <= (hi_ext >= den_ext);
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_step
		logic [D_W:0] trial;
		logic [D_W:0] diff;
		logic         ge;
		logic [Q_W:0] qn;

		always_comb begin
			trial = {rem_s[k-1], low_s[k-1][Q_W-1]};
			diff  = trial - {1'b0, den_s[k-1]};
			ge    = (trial >= {1'b0, den_s[k-1]});
			qn    = {quo_s[k-1], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k]  <= qn[Q_W-1:0];
				ovf_s[k]  <= ovf_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end

		if (k < Q_W) begin : g_mid
			logic [Q_W:0] ln;

			assign ln = {low_s[k-1], 1'b0};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
					low_s[k] <= ln[Q_W-1:0];
					den_s[k] <= den_s[k-1];
				end
			end
		end
	end

	assign out_v    = v_s[Q_W];
	assign quo      = quo_s[Q_W];
	assign ovf      = ovf_s[Q_W];
	assign side_out = side_s[Q_W];

endmodule

>>> rtl/core/sis_isqrt.sv
module sis_isqrt import sis_pkg::*; #(
	parameter int R_W = NQ_W,
	parameter int S_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [2*R_W-1:0] x,
	input  logic [S_W-1:0]   side_in,
	output logic             out_v,
	output logic [R_W-1:0]   root,
	output logic [S_W-1:0]   side_out
);

	localparam int X_W = 2 * R_W;

	logic           v_s    [R_W+1];
	logic [X_W-1:0] r_s    [R_W+1];
	logic [S_W-1:0] side_s [R_W+1];
	logic [X_W-1:0] x_s    [R_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= x;
			r_s[0]    <= '0;
			side_s[0] <= side_in;
		end
	end

	// Digit-by-digit square root: one result bit per stage, starting from the
	// top power of four.
	for (genvar k = 1; k <= R_W; k++) begin : g_step
		localparam logic [X_W-1:0] BIT = X_W'(1) << (X_W - 2 * k);
		logic [X_W-1:0] trial;
		logic           ge;

		always_comb begin
			trial = r_s[k-1] + BIT;
			ge    = (x_s[k-1] >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k]    <= ge ? ((r_s[k-1] >> 1) + BIT) : (r_s[k-1] >> 1);
				side_s[k] <= side_s[k-1];
			end
		end

		if (k < R_W) begin : g_mid
			always_ff @(posedge clk) begin
				if (en) begin
					x_s[k] <= ge ? (x_s[k-1] - trial) : x_s[k-1];
				end
			end
		end
	end

	assign out_v    = v_s[R_W];
	assign root     = r_s[R_W][R_W-1:0];
	assign side_out = side_s[R_W];

endmodule

>>> rtl/core/sellmeier_index_and_slope.sv
// Channel      Handshake              Payload
// cfg          cfg_valid / cfg_ready  cfg_index, cfg_data
// wavelength   wl_valid / wl_stall    wavelength
// result       res_valid / res_stall  index_value, index_slope, status
//
// One wavelength beat is taken per cycle while wl_stall is low.
// L^2 takes five stages of reciprocal products; the rest of the depth is set by the
// bit-per-stage units in series: the term dividers (62), the square root (33) and
// the slope divider (34). Reset loads the default glass coefficients and empties the pipeline.
// The whole pipeline holds while a result beat is stalled, so wl_stall follows
// res_stall whenever the output register is full. cfg_ready is always high.
module sellmeier_index_and_slope import sis_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [COEF_W-1:0]          cfg_data,
	input  logic                       wl_valid,
	output logic                       wl_stall,
	input  logic signed [WL_W-1:0]     wavelength,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic [NQ_W-1:0]            index_value,
	output logic signed [SLOPE_W-1:0]  index_slope,
	output logic [STATUS_W-1:0]        status
);

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} l2_side_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic             pos;
	} ti0_side_t;

	typedef struct packed {
		logic             neg;
		logic             bad;
		logic             big;
		logic [PMU_W-1:0] pmu;
	} sq_side_t;

	typedef struct packed {
		logic            neg;
		logic            bad;
		logic [NQ_W-1:0] nq;
	} sl_side_t;

	logic [COEF_W-1:0] b_q [NUM_TERMS];
	logic [COEF_W-1:0] c_q [NUM_TERMS];
	logic              en;

	assign cfg_ready = 1'b1;
	assign en        = !res_valid || !res_stall;
	assign wl_stall  = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q[0] <= B1_RESET;
			b_q[1] <= B2_RESET;
			b_q[2] <= B3_RESET;
			c_q[0] <= C1_RESET;
			c_q[1] <= C2_RESET;
			c_q[2] <= C3_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_B1: b_q[0] <= cfg_data;
				REG_B2: b_q[1] <= cfg_data;
				REG_B3: b_q[2] <= cfg_data;
				REG_C1: c_q[0] <= cfg_data;
				REG_C2: c_q[1] <= cfg_data;
				REG_C3: c_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: magnitude and its square.
	logic [WL_W-1:0]     wl_u;
	logic [MAG_W-1:0]    mag_in;
	logic [L2_SQ_W-1:0]  sq_in;
	logic                v_s1;
	l2_side_t            side_s1;
	logic [L2_SQ_W-1:0]  sq_s1;

	assign wl_u   = wavelength;
	assign mag_in = wl_u[WL_W-1] ? (~wl_u + 1'b1) : wl_u;
	assign sq_in  = mag_in * mag_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= wl_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.neg <= wl_u[WL_W-1];
			side_s1.mag <= mag_in;
			sq_s1       <= sq_in;
		end
	end

	// L^2 in Q.32 is floor((m^2 * 2^24 + 500000) / 10^6), which equals
	// floor((m^2 * 2^18 + 7812) / 15625). Splitting m^2 = a * 15625 + r first
	// keeps both reciprocal products within 32 by 32 bits.
	logic                v_s1b, v_s1c, v_s1d, v_s1e;
	l2_side_t            side_s1b, side_s1c, side_s1d, side_s1e;
	logic [L2_SQ_W-1:0]  sq_s1b;
	logic [L2_P_W-1:0]   p1_s1b, p2_s1d;
	logic [L2_A_W-1:0]   a_in, a_s1c, a_s1d;
	logic [L2_R_W-1:0]   r_in;
	logic [L2_SQ_W-1:0]  n2_in, n2_s1c;
	logic [L2_W-1:0]     l2q_s1e;

	assign a_in  = p1_s1b[L2_SH+L2_A_W-1:L2_SH];
	assign r_in  = L2_R_W'(sq_s1b - L2_SQ_W'(a_in) * L2_ODD);
	assign n2_in = {r_in, {L2_FR_W{1'b0}}} + L2_BIAS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1b <= 1'b0;
			v_s1c <= 1'b0;
			v_s1d <= 1'b0;
			v_s1e <= 1'b0;
		end else if (en) begin
			v_s1b <= v_s1;
			v_s1c <= v_s1b;
			v_s1d <= v_s1c;
			v_s1e <= v_s1d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1b   <= L2_P_W'(sq_s1) * L2_P_W'(L2_RCP);
			sq_s1b   <= sq_s1;
			side_s1b <= side_s1;
			a_s1c    <= a_in;
			n2_s1c   <= n2_in;
			side_s1c <= side_s1b;
			p2_s1d   <= L2_P_W'(n2_s1c) * L2_P_W'(L2_RCP);
			a_s1d    <= a_s1c;
			side_s1d <= side_s1c;
			l2q_s1e  <= {a_s1d, {L2_FR_W{1'b0}}} + L2_W'(p2_s1d[L2_P_W-1:L2_SH]);
			side_s1e <= side_s1d;
		end
	end

	logic            l2_v;
	logic [L2_W-1:0] l2q;
	l2_side_t        l2_side;

	assign l2_v    = v_s1e;
	assign l2q     = l2q_s1e;
	assign l2_side = side_s1e;

	// Stage 2: distance from each pole.
	logic              v_s2, neg_s2;
	logic [MAG_W-1:0]  mag_s2;
	logic [L2_W-1:0]   l2q_s2;
	logic [COEF_W-1:0] ad_s2   [NUM_TERMS];
	logic              pos_s2  [NUM_TERMS];
	logic              pole_s2 [NUM_TERMS];

	for (genvar k = 0; k < NUM_TERMS; k++) begin : g_diff
		logic [DIFF_W-1:0] d;
		logic [DIFF_W-1:0] dn;

		assign d  = DIFF_W'(l2q) - {1'b0, c_q[k]};
		assign dn = ~d + 1'b1;

		always_ff @(posedge clk) begin
			if (en) begin
				ad_s2[k]   <= d[DIFF_W-1] ? dn[COEF_W-1:0] : d[COEF_W-1:0];
				pos_s2[k]  <= !d[DIFF_W-1] && (d != '0);
				pole_s2[k] <= (d == '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= l2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= l2_side.neg;
			mag_s2 <= l2_side.mag;
			l2q_s2 <= l2q;
		end
	end

	// Stages 3 and 4: wide products as registered 24x24 partial products.
	logic              v_s3, neg_s3, v_s4, neg_s4;
	logic [MAG_W-1:0]  mag_s3, mag_s4;
	pp_t               pp_bl_s3 [NUM_TERMS];
	pp_t               pp_bc_s3 [NUM_TERMS];
	pp_t               pp_dd_s3 [NUM_TERMS];
	logic [COEF_W-1:0] ad_s3    [NUM_TERMS];
	logic              pos_s3   [NUM_TERMS];
	logic              pole_s3  [NUM_TERMS];
	logic [PROD_W-1:0] bl_s4    [NUM_TERMS];
	logic [PROD_W-1:0] bc_s4    [NUM_TERMS];
	logic [PROD_W-1:0] dd_s4    [NUM_TERMS];
	logic [COEF_W-1:0] ad_s4    [NUM_TERMS];
	logic              pos_s4   [NUM_TERMS];
	logic              pole_s4  [NUM_TERMS];

	for (genvar k = 0; k < NUM_TERMS; k++) begin : g_mul
		always_ff @(posedge clk) begin
			if (en) begin
				pp_bl_s3[k] <= mul_split(b_q[k], COEF_W'(l2q_s2));
				pp_bc_s3[k] <= mul_split(b_q[k], c_q[k]);
				pp_dd_s3[k] <= mul_split(ad_s2[k], ad_s2[k]);
				ad_s3[k]    <= ad_s2[k];
				pos_s3[k]   <= pos_s2[k];
				pole_s3[k]  <= pole_s2[k];
				bl_s4[k]    <= mul_join(pp_bl_s3[k]);
				bc_s4[k]    <= mul_join(pp_bc_s3[k]);
				dd_s4[k]    <= mul_join(pp_dd_s3[k]);
				ad_s4[k]    <= ad_s3[k];
				pos_s4[k]   <= pos_s3[k];
				pole_s4[k]  <= pole_s3[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3 <= neg_s2;
			mag_s3 <= mag_s2;
			neg_s4 <= neg_s3;
			mag_s4 <= mag_s3;
		end
	end

	// Term dividers: the index terms carry their sign, the slope terms their
	// pole flag; lane 0 also carries the wavelength.
	logic            ti_v   [NUM_TERMS];
	logic [TQ_W-1:0] ti_q   [NUM_TERMS];
	logic            ti_ovf [NUM_TERMS];
	logic            ti_pos [NUM_TERMS];
	logic            ui_v   [NUM_TERMS];
	logic [TQ_W-1:0] ui_q   [NUM_TERMS];
	logic            ui_ovf [NUM_TERMS];
	logic            ui_pole[NUM_TERMS];
	ti0_side_t       ti0_in, ti0_out;

	assign ti0_in.neg = neg_s4;
	assign ti0_in.mag = mag_s4;
	assign ti0_in.pos = pos_s4[0];
	assign ti_pos[0]  = ti0_out.pos;

	for (genvar k = 0; k < NUM_TERMS; k++) begin : g_tdiv
		if (k == 0) begin : g_lead
			sis_udiv #(
				.N_W(PROD_W), .D_W(COEF_W), .Q_W(TQ_W), .S_W($bits(ti0_side_t))
			) u_ti (
				.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s4), .num(bl_s4[k]),
				.den(ad_s4[k]), .side_in(ti0_in), .out_v(ti_v[k]), .quo(ti_q[k]),
				.ovf(ti_ovf[k]), .side_out(ti0_out)
			);
		end else begin : g_rest
			sis_udiv #(
				.N_W(PROD_W), .D_W(COEF_W), .Q_W(TQ_W), .S_W(1)
			) u_ti (
				.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s4), .num(bl_s4[k]),
				.den(ad_s4[k]), .side_in(pos_s4[k]), .out_v(ti_v[k]), .quo(ti_q[k]),
				.ovf(ti_ovf[k]), .side_out(ti_pos[k])
			);
		end

		sis_udiv #(
			.N_W(UNUM_W), .D_W(PROD_W), .Q_W(TQ_W), .S_W(1)
		) u_ui (
			.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s4), .num({bc_s4[k], 24'b0}),
			.den(dd_s4[k]), .side_in(pole_s4[k]), .out_v(ui_v[k]), .quo(ui_q[k]),
			.ovf(ui_ovf[k]), .side_out(ui_pole[k])
		);
	end

	// Stage 5: saturate the terms and sum the radicand and the slope terms.
	logic              v5_in, pole5_in;
	logic [RAD_W-1:0]  rad5_in;
	logic [USUM_W-1:0] usum5_in;

	always_comb begin
		logic [TQ_W-1:0] t;
		logic [TQ_W-1:0] u;
		v5_in    = 1'b1;
		pole5_in = 1'b0;
		rad5_in  = RAD_ONE;
		usum5_in = '0;
		for (int k = 0; k < NUM_TERMS; k++) begin
			t        = (ti_ovf[k] || ti_q[k] > LIM60) ? LIM60 : ti_q[k];
			u        = (ui_ovf[k] || ui_q[k] > LIM60) ? LIM60 : ui_q[k];
			rad5_in  = ti_pos[k] ? rad5_in + RAD_W'(t) : rad5_in - RAD_W'(t);
			usum5_in = usum5_in + USUM_W'(u);
			pole5_in = pole5_in || ui_pole[k];
			v5_in    = v5_in && ti_v[k] && ui_v[k];
		end
	end

	logic              v_s5, neg_s5, pole_s5;
	logic [MAG_W-1:0]  mag_s5;
	logic [RAD_W-1:0]  rad_s5;
	logic [USUM_W-1:0] usum_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s5  <= ti0_out.neg;
			mag_s5  <= ti0_out.mag;
			pole_s5 <= pole5_in;
			rad_s5  <= rad5_in;
			usum_s5 <= usum5_in;
		end
	end

	// Stage 6: classify the radicand and start the m * U product.
	logic             v_s6, neg_s6, bad_s6, big_s6;
	logic [RAD_W-1:0] x_s6;
	logic [PM_W-1:0]  pm0_s6, pm1_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s6 <= neg_s5;
			bad_s6 <= pole_s5 || (!neg_s5 && (rad_s5[RAD_W-1] || rad_s5 == '0));
			big_s6 <= !rad_s5[RAD_W-1] && (rad_s5[RAD_W-2:36] != '0);
			x_s6   <= {rad_s5[35:0], 28'b0};
			pm0_s6 <= mag_s5 * usum_s5[30:0];
			pm1_s6 <= mag_s5 * usum_s5[USUM_W-1:31];
		end
	end

	// Stage 7: finish the m * U product.
	logic             v_s7;
	logic [RAD_W-1:0] x_s7;
	sq_side_t         sq_in_s7, sq_out;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s7         <= x_s6;
			sq_in_s7.neg <= neg_s6;
			sq_in_s7.bad <= bad_s6;
			sq_in_s7.big <= big_s6;
			sq_in_s7.pmu <= {31'b0, pm0_s6} + {pm1_s6, 31'b0};
		end
	end

	logic            sq_v;
	logic [NQ_W-1:0] sq_root;

	sis_isqrt #(
		.R_W(NQ_W), .S_W($bits(sq_side_t))
	) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s7), .x(x_s7), .side_in(sq_in_s7),
		.out_v(sq_v), .root(sq_root), .side_out(sq_out)
	);

	// Stage 8: pick the index and scale it for the slope divisor.
	logic            nq8_in;
	logic [NQ_W-1:0] nq_sel;
	logic            v_s8;
	logic [DQ_W-1:0] dq_s8;
	logic [SL_NUM_W-1:0] sn_s8;
	sl_side_t        sl_in_s8, sl_out;

	assign nq8_in = sq_out.big;
	assign nq_sel = sq_out.neg ? AVG_INDEX : (nq8_in ? '1 : sq_root);

	always_ff @(posedge clk) begin
		if (en) begin
			dq_s8        <= L2_DIV * nq_sel;
			sn_s8        <= {sq_out.pmu, 42'b0};
			sl_in_s8.neg <= sq_out.neg;
			sl_in_s8.bad <= sq_out.bad;
			sl_in_s8.nq  <= nq_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s5 <= v5_in;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= sq_v;
		end
	end

	logic              sl_v;
	logic [SL_Q_W-1:0] sl_q;
	logic              sl_ovf;

	sis_udiv #(
		.N_W(SL_NUM_W), .D_W(DQ_W), .Q_W(SL_Q_W), .S_W($bits(sl_side_t))
	) u_slope_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s8), .num(sn_s8), .den(dq_s8),
		.side_in(sl_in_s8), .out_v(sl_v), .quo(sl_q), .ovf(sl_ovf), .side_out(sl_out)
	);

	// Output register: saturation, sign and status.
	logic [SL_Q_W-1:0]  lim;
	logic [SLOPE_W-1:0] smag;
	logic               out_v_q;
	logic [NQ_W-1:0]    index_q;
	logic [SLOPE_W-1:0] slope_q;
	logic [STATUS_W-1:0] status_q;

	assign lim  = sl_out.neg ? LIM_POS : LIM_NEG;
	assign smag = (sl_ovf || sl_q > lim) ? lim[SLOPE_W-1:0] : sl_q[SLOPE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= sl_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sl_out.bad) begin
				index_q  <= '1;
				slope_q  <= LIM_POS[SLOPE_W-1:0];
				status_q <= ST_INVALID;
			end else begin
				index_q  <= sl_out.nq;
				slope_q  <= sl_out.neg ? smag : (~smag + 1'b1);
				status_q <= sl_out.neg ? ST_AVERAGE : ST_NORMAL;
			end
		end
	end

	assign res_valid   = out_v_q;
	assign index_value = index_q;
	assign index_slope = slope_q;
	assign status      = status_q;

endmodule

>>> tb/sv/tb.sv
module tb import sis_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 200;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};

	typedef struct packed {
		logic [NQ_W-1:0]           index_value;
		logic signed [SLOPE_W-1:0] index_slope;
		logic [STATUS_W-1:0]       status;
	} index_result_t;

	class index_scoreboard;
		index_result_t pending[$];
		int errors = 0;

		task report(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function void note(index_result_t r);
			pending.push_back(r);
		endfunction

		task check(index_result_t got);
			index_result_t want;
			if (pending.size() == 0) begin
				report($sformatf("result with nothing pending: %h", got));
				return;
			end
			want = pending.pop_front();
			if (got.index_value !== want.index_value)
				report($sformatf("index_value %h want %h", got.index_value, want.index_value));
			if (got.index_slope !== want.index_slope)
				report($sformatf("index_slope %h want %h", got.index_slope, want.index_slope));
			if (got.status !== want.status)
				report($sformatf("status %0d want %0d", got.status, want.status));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COEF_W-1:0] cfg_data = '0;
	logic wl_valid = 1'b0;
	logic wl_stall;
	logic signed [WL_W-1:0] wavelength = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [NQ_W-1:0] index_value;
	logic signed [SLOPE_W-1:0] index_slope;
	logic [STATUS_W-1:0] status;

	index_scoreboard sb = new();
	logic [COEF_W-1:0] coef_b [NUM_TERMS];
	logic [COEF_W-1:0] coef_c [NUM_TERMS];
	bit quiet = 1'b0;
	bit any_fire;
	int idle_cycles = 0;

	always #2 clk = ~clk;

	sellmeier_index_and_slope i_dut (.*);

	function automatic logic [63:0] wl_square_q32(logic [15:0] mag);
		return (64'(mag) * 64'(mag) * (64'd1 << 24) + 64'd500000) / 64'd1000000;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] clip60(logic [127:0] x);
		return (x > (128'd1 << 60)) ? (64'd1 << 60) : x[63:0];
	endfunction

	function automatic index_result_t predict_index(logic [15:0] raw);
		index_result_t res;
		logic neg, pole;
		logic [15:0] mag;
		logic [63:0] l2, ad, t, usum, nq, lim, slope;
		logic signed [63:0] d, rad;
		logic [127:0] q;
		neg = raw[15];
		mag = neg ? 16'(17'h10000 - raw) : raw;
		l2 = wl_square_q32(mag);
		rad = 64'sd1 <<< 32;
		usum = 0;
		pole = 1'b0;
		for (int i = 0; i < NUM_TERMS; i++) begin
			d = $signed(l2) - $signed({16'd0, coef_c[i]});
			ad = (d < 0) ? 64'(-d) : 64'(d);
			if (d == 0) begin
				pole = 1'b1;
			end else begin
				t = clip60((128'(coef_b[i]) * 128'(l2)) / 128'(ad));
				rad = (d > 0) ? rad + $signed(t) : rad - $signed(t);
				usum += clip60(((128'(coef_b[i]) * 128'(coef_c[i])) << 24)
					/ (128'(ad) * 128'(ad)));
			end
		end
		if (pole || (!neg && rad <= 0)) begin
			res.index_value = '1;
			res.index_slope = 32'sh7FFF_FFFF;
			res.status = ST_INVALID;
			return res;
		end
		if (neg) begin
			nq = 64'(AVG_INDEX);
			res.status = ST_AVERAGE;
		end else begin
			res.status = ST_NORMAL;
			if (rad >= (64'sd1 <<< 36)) nq = 64'hFFFF_FFFF;
			else nq = int_sqrt(64'(rad) << 28);
			if (nq > 64'hFFFF_FFFF) nq = 64'hFFFF_FFFF;
		end
		q = ((128'(mag) * 128'(usum)) << 42) / (128'd1000000 * 128'(nq));
		lim = neg ? 64'h7FFF_FFFF : 64'h8000_0000;
		slope = (q > 128'(lim)) ? lim : q[63:0];
		if (!neg) slope = (64'h1_0000_0000 - slope) & 64'hFFFF_FFFF;
		res.index_value = nq[31:0];
		res.index_slope = slope[31:0];
		return res;
	endfunction

	// Handshake outputs settle between edges, so beats are judged at the falling edge.
	always @(negedge clk) begin
		any_fire = (wl_valid && !wl_stall) || (res_valid && !res_stall)
			|| (cfg_valid && cfg_ready);
		if (res_valid && !res_stall)
			sb.check('{index_value, index_slope, status});
	end

	always @(posedge clk) begin
		if (!arst_n || any_fire) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 17);
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			res_stall <= 1'b0;
			if (!quiet) repeat ($urandom_range(0, 30)) @(posedge clk);
		end
	end

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
		bit ok;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
		case (idx)
			REG_B1: coef_b[0] = val;
			REG_B2: coef_b[1] = val;
			REG_B3: coef_b[2] = val;
			REG_C1: coef_c[0] = val;
			REG_C2: coef_c[1] = val;
			REG_C3: coef_c[2] = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_coefs(logic [COEF_W-1:0] b1, logic [COEF_W-1:0] b2,
		logic [COEF_W-1:0] b3, logic [COEF_W-1:0] c1, logic [COEF_W-1:0] c2,
		logic [COEF_W-1:0] c3);
		cfg_write(REG_B1, b1);
		cfg_write(REG_B2, b2);
		cfg_write(REG_B3, b3);
		cfg_write(REG_C1, c1);
		cfg_write(REG_C2, c2);
		cfg_write(REG_C3, c3);
	endtask

	task automatic send_wavelength(logic [15:0] w);
		bit ok;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			wl_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		wl_valid <= 1'b1;
		wavelength <= w;
		do begin
			@(negedge clk);
			ok = !wl_stall;
			@(posedge clk);
		end while (!ok);
		sb.note(predict_index(w));
	endtask

	// The block is idle only once every pending result has left and the pipe has run dry.
	task automatic drain();
		wl_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] random_wavelength(logic [15:0] hot);
		case ($urandom_range(0, 9))
			0, 1: return 16'($urandom);
			2: return 16'(-$signed(17'($urandom_range(3000, 24000))));
			3: return hot + 16'($urandom_range(0, 2)) - 16'd1;
			4: return 16'($urandom_range(0, 64));
			default: return 16'($urandom_range(3000, 24000));
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] random_coef();
		logic [COEF_W-1:0] v;
		v = {$urandom, $urandom};
		return v >> $urandom_range(0, 40);
	endfunction

	task automatic random_items(int count, logic [15:0] hot);
		repeat (count) send_wavelength(random_wavelength(hot));
	endtask

	initial begin
		logic [15:0] hot;
		logic [63:0] l2;
		coef_b[0] = B1_RESET; coef_b[1] = B2_RESET; coef_b[2] = B3_RESET;
		coef_c[0] = C1_RESET; coef_c[1] = C2_RESET; coef_c[2] = C3_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset coefficients: extremes, zero, the sign boundary and visible light.
		send_wavelength(16'h0000);
		send_wavelength(16'h0001);
		send_wavelength(16'hFFFF);
		send_wavelength(16'h7FFF);
		send_wavelength(16'h8000);
		send_wavelength(16'h8001);
		send_wavelength(16'd9440);
		send_wavelength(-16'sd9440);
		send_wavelength(16'd16000);
		send_wavelength(16'd4800);
		send_wavelength(16'd24000);
		send_wavelength(16'h5555);
		send_wavelength(16'hAAAA);
		drain();

		load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		send_wavelength(16'h7FFF);
		send_wavelength(16'h8000);
		random_items(80, 16'h7FFF);
		drain();

		load_coefs('0, '0, '0, '0, '0, '0);
		send_wavelength(16'h0000);
		send_wavelength(16'h0001);
		random_items(50, 16'h0000);
		drain();

		// A C term equal to the wavelength square is a pole for either sign.
		hot = 16'($urandom_range(4800, 16000));
		l2 = wl_square_q32(hot);
		load_coefs(B1_RESET, B2_RESET, B3_RESET, l2[47:0], C2_RESET, C3_RESET);
		send_wavelength(hot);
		send_wavelength(-hot);
		send_wavelength(hot + 16'd1);
		send_wavelength(hot - 16'd1);
		random_items(60, hot);
		drain();

		// A huge B below its resonance drives the radicand negative.
		load_coefs(COEF_MAX, '0, '0, 48'h100_0000_0000, '0, '0);
		random_items(100, 16'd100);
		drain();

		// Just above a strong resonance the index overflows Q2.30.
		l2 = wl_square_q32(16'd8000);
		load_coefs(COEF_MAX, B2_RESET, '0, l2[47:0] - 48'd1000, C2_RESET, '0);
		random_items(100, 16'd8000);
		drain();

		cfg_write(REG_SPARE_LO, COEF_MAX);
		cfg_write(REG_SPARE_HI, '0);
		for (int p = 0; p < 5; p++) begin
			load_coefs(random_coef(), random_coef(), random_coef(),
				random_coef(), random_coef(), random_coef());
			hot = 16'($urandom_range(3000, 24000));
			l2 = wl_square_q32(hot);
			if (p[0]) cfg_write(REG_C2, l2[47:0]);
			random_items(100, hot);
			drain();
		end

		quiet = 1'b1;
		load_coefs(B1_RESET, B2_RESET, B3_RESET, C1_RESET, C2_RESET, C3_RESET);
		random_items(200, 16'd9440);
		drain();

		while (sb.pending.size() != 0) begin
			sb.report("expected result never arrived");
			void'(sb.pending.pop_front());
		end
		if (sb.errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
